// ----- rtl/abl_pkg.sv -----
// Shared types and constants of the block level meter.
package abl_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 14;
    localparam int MEAN_W      = 31;
    localparam int LEVEL_W     = 15;
    localparam int FRAC_W      = 24;
    localparam int EXP_W       = 5;
    localparam int LOG_W       = EXP_W + FRAC_W;
    localparam int K_W         = 28;
    localparam int PROD_W      = LOG_W + K_W;
    localparam int MIN_BLOCK   = 64;

    localparam logic [CFG_W-1:0]   RESET_LENGTH = CFG_W'(1000);
    // Scale factor: round(0.055 * ln(2) * 2^32).
    localparam logic [K_W-1:0]     LEVEL_K      = K_W'(163737446);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = '1;
    localparam logic [EXP_W-1:0]   EXP_TOP      = EXP_W'(MEAN_W - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // an input transaction completes this cycle
        logic div_step;   // one restoring division step
        logic norm_load;  // load 1 + quotient into the log unit
        logic norm_step;  // shift the log operand left by one bit
        logic log_step;   // one squaring round of the log unit
        logic scale;      // multiply the log2 value by the level constant
        logic finish;     // round and load the result registers
    } t_abl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic blk_end;       // the next sample completes the block
        logic last_pending;  // a finished block sum is being handed over
        logic norm_done;     // the log operand is normalized
    } t_abl_stat;

endpackage

// ----- rtl/abl_ctrl.sv -----
// Controller state machine of the block level meter.
module abl_ctrl
    import abl_pkg::*;
#(
    parameter int SUM_W = 44,
    parameter int CNT_W = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_abl_stat i_stat,
    output t_abl_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_LOG  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_RND  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             busy;

    // A block-ending sample waits until the unit is free for its sum.
    assign busy       = (r_state != S_IDLE) || i_stat.last_pending;
    assign o_in_ready = !(i_stat.blk_end && busy);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.take     = i_in_valid && o_in_ready;
        case (r_state)
            S_IDLE: begin
                if (i_stat.last_pending) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.norm_load = 1'b1;
                n_state         = S_NORM;
            end
            S_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = S_LOG;
                    n_cnt   = '0;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_LOG: begin
                o_cmd.log_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.scale = 1'b1;
                n_state     = S_RND;
            end
            S_RND: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/abl_dpath.sv -----
// Datapath of the block level meter: accumulator, divider, log unit and result registers.
module abl_dpath
    import abl_pkg::*;
#(
    parameter int MAX_BLOCK = 8192,
    parameter int N_W       = 14,
    parameter int SUM_W     = 44
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_abl_cmd                   i_cmd,
    output t_abl_stat                  o_stat,
    output logic [LEVEL_W-1:0]         o_level,
    output logic [MEAN_W-1:0]          o_mean_square
);

    logic [CFG_W-1:0]          r_block_length;
    logic [N_W-1:0]            n_eff;
    logic [N_W-1:0]            r_count;
    logic [N_W-1:0]            count_inc;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [MEAN_W-1:0]         r_sq;
    logic                      r_sq_v;
    logic                      r_last;
    logic [SUM_W-1:0]          r_sum;

    logic [SUM_W-1:0]          r_div;
    logic [N_W-1:0]            r_rem;
    logic [N_W-1:0]            r_n;
    logic [N_W:0]              rem_sh;
    logic [N_W:0]              rem_nx;
    logic                      q_bit;

    logic [MEAN_W-1:0]         r_y;
    logic [EXP_W-1:0]          r_e;
    logic [FRAC_W-1:0]         r_frac;
    logic [2*MEAN_W-1:0]       y_sq;
    logic [MEAN_W:0]           y_t;
    logic [PROD_W-1:0]         r_prod;
    logic [PROD_W:0]           rnd_sum;
    logic [LEVEL_W:0]          lv;

    // Block length clamped to the supported range.
    always_comb begin
        if (32'(r_block_length) < 32'(MIN_BLOCK)) begin
            n_eff = N_W'(MIN_BLOCK);
        end else if (32'(r_block_length) > 32'(MAX_BLOCK)) begin
            n_eff = N_W'(MAX_BLOCK);
        end else begin
            n_eff = N_W'(r_block_length);
        end
    end

    assign count_inc           = r_count + 1'b1;
    assign sq_full             = i_sample * i_sample;
    assign o_stat.blk_end      = (count_inc >= n_eff);
    assign o_stat.last_pending = r_sq_v && r_last;
    assign o_stat.norm_done    = r_y[MEAN_W-1];

    // Configuration register and the accumulator with its sample counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= RESET_LENGTH;
            r_count        <= '0;
            r_sq_v         <= 1'b0;
            r_last         <= 1'b0;
            r_sum          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_block_length <= i_cfg_wdata;
            end
            r_sq_v <= i_cmd.take;
            r_last <= i_cmd.take && o_stat.blk_end;
            if (i_cmd.take) begin
                r_count <= o_stat.blk_end ? '0 : count_inc;
            end
            if (r_sq_v) begin
                if (r_last) begin
                    r_sum <= '0;
                end else begin
                    r_sum <= r_sum + SUM_W'(r_sq);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sq <= sq_full[MEAN_W-1:0];
        end
    end

    // Restoring divider; the quotient shifts into the dividend register.
    assign rem_sh = {r_rem, r_div[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_n});
    assign rem_nx = q_bit ? (rem_sh - {1'b0, r_n}) : rem_sh;

    // Log unit: the squaring product is wide enough to hold values below four.
    assign y_sq = {{MEAN_W{1'b0}}, r_y} * {{MEAN_W{1'b0}}, r_y};
    assign y_t  = y_sq[2*MEAN_W-1:MEAN_W-1];

    assign rnd_sum = {1'b0, r_prod} + ((PROD_W+1)'(1) << 41);
    assign lv      = rnd_sum[PROD_W:42];

    always_ff @(posedge i_clk) begin
        if (o_stat.last_pending) begin
            r_div <= r_sum + SUM_W'(r_sq);
            r_rem <= '0;
            r_n   <= n_eff;
        end else if (i_cmd.div_step) begin
            r_div <= {r_div[SUM_W-2:0], q_bit};
            r_rem <= rem_nx[N_W-1:0];
        end

        if (i_cmd.norm_load) begin
            r_y <= r_div[MEAN_W-1:0] + 1'b1;
            r_e <= EXP_TOP;
        end else if (i_cmd.norm_step) begin
            r_y <= {r_y[MEAN_W-2:0], 1'b0};
            r_e <= r_e - 1'b1;
        end else if (i_cmd.log_step) begin
            r_y    <= y_t[MEAN_W] ? y_t[MEAN_W:1] : y_t[MEAN_W-1:0];
            r_frac <= {r_frac[FRAC_W-2:0], y_t[MEAN_W]};
        end

        if (i_cmd.scale) begin
            r_prod <= {{K_W{1'b0}}, r_e, r_frac} * {{LOG_W{1'b0}}, LEVEL_K};
        end

        if (i_cmd.finish) begin
            o_level       <= lv[LEVEL_W] ? LEVEL_MAX : lv[LEVEL_W-1:0];
            o_mean_square <= r_div[MEAN_W-1:0];
        end
    end

endmodule

// ----- rtl/audio_block_level_meter_core.sv -----
// Top level of the block mean-square level meter.
//
// The meter squares each signed 16-bit sample and accumulates the squares over a
// block whose length is the block_length register, clamped to 64 up to MAX_BLOCK
// samples (reset value 1000). The sample that completes a block yields one result
// transaction carrying mean_square, the block sum divided by the length and
// floored, and level, 0.055*ln(1 + mean_square) in unsigned Q1.14 rounded to
// nearest. Samples are taken at one per cycle; the accumulator clears itself when
// a block ends and the next block starts at once. The finished sum goes to a
// shared post-processing unit: a restoring divider that retires one quotient bit
// per cycle, a normalizing shifter that moves one bit per cycle (fewer bits for
// large means), a log2 unit that produces one fraction bit per cycle by repeated
// squaring, and a multiply and a rounding stage. A result is held in output
// registers until the consumer takes it. Only a block-ending sample can stall: it
// is not accepted while the previous block's result is still being computed or is
// still waiting at the output. The block length may be written only while the
// meter is idle.
module audio_block_level_meter_core
    import abl_pkg::*;
#(
    parameter int MAX_BLOCK = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [LEVEL_W-1:0]         o_level,
    output logic [MEAN_W-1:0]          o_mean_square
);

    // Width of the sample counter and of the latched block length.
    localparam int N_W   = $clog2(MAX_BLOCK + 1);
    // Width of the block sum: each square is at most 2^30.
    localparam int SUM_W = $clog2(MAX_BLOCK) + 31;
    // Width of the step counter for the divider and the log rounds.
    localparam int CNT_W = $clog2(SUM_W);

    t_abl_cmd  cmd;
    t_abl_stat stat;

    abl_ctrl #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    abl_dpath #(
        .MAX_BLOCK (MAX_BLOCK),
        .N_W       (N_W),
        .SUM_W     (SUM_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_sample      (i_sample),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_level       (o_level),
        .o_mean_square (o_mean_square)
    );

endmodule

// ----- rtl/abl_checker.sv -----
// Port-level checker of the block level meter and its bind statement.
module abl_checker
    import abl_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_we,
    input logic [CFG_W-1:0]           i_cfg_wdata,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic signed [SAMPLE_W-1:0] i_sample,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [LEVEL_W-1:0]         o_level,
    input logic [MEAN_W-1:0]          o_mean_square
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_level) && $stable(o_mean_square))
        else $error("result payload changed while stalled");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // The mean of squared 16-bit samples never exceeds 2^30.
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_mean_square <= MEAN_W'(32'h4000_0000))
        else $error("mean square out of range");

    // Silence gives a level of zero.
    a_zero_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mean_square == '0 |-> o_level == '0)
        else $error("nonzero level for a silent block");

endmodule

bind audio_block_level_meter_core abl_checker u_abl_checker (.*);

// ----- verif/level_meter_checker.sv -----
// Checker for the block level meter: predicts each block result and compares it field by field.
module level_meter_checker
    import abl_pkg::*;
#(
    parameter int MAX_BLOCK = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [LEVEL_W-1:0]         i_level,
    input  logic [MEAN_W-1:0]          i_mean_square,
    output int                         o_fail_count,
    output int                         o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [MEAN_W-1:0]  mean_square;
    } t_block_result;

    t_block_result    block_results_due[$];
    logic [CFG_W-1:0] length_reg = RESET_LENGTH;
    longint unsigned  energy_acc = 0;
    int               samples_taken = 0;
    int               fails = 0;

    initial begin
        o_fail_count  = 0;
        o_results_due = 0;
    end

    // Register values outside the legal range saturate to the nearest bound.
    function automatic int block_size(input logic [CFG_W-1:0] len);
        if (len < MIN_BLOCK) begin
            return MIN_BLOCK;
        end
        if (len > MAX_BLOCK) begin
            return MAX_BLOCK;
        end
        return int'(len);
    endfunction

    // log2(1 + mean) by repeated squaring, scaled by 0.055*ln(2) and rounded to Q1.14.
    function automatic logic [LEVEL_W-1:0] level_from_mean(input longint unsigned mean);
        longint unsigned x;
        longint unsigned y;
        longint unsigned frac;
        longint unsigned log2_val;
        longint unsigned scaled;
        int unsigned     msb;
        int              i;
        x   = mean + 1;
        msb = 0;
        while (msb < 62 && (x >> (msb + 1)) != 0) begin
            msb++;
        end
        y    = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
        frac = 0;
        for (i = 0; i < FRAC_W; i++) begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30)) begin
                frac = frac | 64'd1;
                y    = y >> 1;
            end
        end
        log2_val = (64'(msb) << FRAC_W) | frac;
        scaled   = (log2_val * 64'(LEVEL_K) + (64'd1 << 41)) >> 42;
        if (scaled > 64'(LEVEL_MAX)) begin
            scaled = 64'(LEVEL_MAX);
        end
        return scaled[LEVEL_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_block_result   got;
        t_block_result   want;
        longint unsigned mean;
        int              len;
        if (!i_rst_n) begin
            length_reg    = RESET_LENGTH;
            energy_acc    = 0;
            samples_taken = 0;
            block_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                length_reg = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                got.level       = i_level;
                got.mean_square = i_mean_square;
                if (block_results_due.size() == 0) begin
                    $error("unexpected result transaction: level %0d, mean_square %0d",
                           got.level, got.mean_square);
                    fails++;
                end else begin
                    want = block_results_due.pop_front();
                    if (got.level !== want.level) begin
                        $error("level mismatch: expected %0d, actual %0d",
                               want.level, got.level);
                        fails++;
                    end
                    if (got.mean_square !== want.mean_square) begin
                        $error("mean_square mismatch: expected %0d, actual %0d",
                               want.mean_square, got.mean_square);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                energy_acc += $unsigned(longint'(i_sample) * longint'(i_sample));
                samples_taken++;
                // A shortened length that the count already meets ends the block now.
                len = block_size(length_reg);
                if (samples_taken >= len) begin
                    mean             = energy_acc / 64'(len);
                    want.level       = level_from_mean(mean);
                    want.mean_square = MEAN_W'(mean);
                    block_results_due.push_back(want);
                    energy_acc    = 0;
                    samples_taken = 0;
                end
            end
        end
        o_fail_count  <= fails;
        o_results_due <= block_results_due.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// Top of the level meter testbench: clock, reset, sample and length stimulus, and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import abl_pkg::*;

    localparam int MAX_BLOCK      = 8192;
    // Cycles to let the post-processing pipeline settle.
    localparam int SETTLE_CYCLES  = 128;
    // Cycles with no transaction on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int RANDOM_RESULTS = 36;
    localparam int PHASE_ITEMS    = 100;

    logic                       i_clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_W-1:0]           cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] pcm_sample = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [LEVEL_W-1:0]         level;
    logic [MEAN_W-1:0]          mean_square;

    int fail_count;
    int results_due;
    int tx_idle_pct   = 30;
    int rx_idle_pct   = 67;
    int items_sent    = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;

    audio_block_level_meter_core #(
        .MAX_BLOCK(MAX_BLOCK)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample     (pcm_sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_level      (level),
        .o_mean_square(mean_square)
    );

    level_meter_checker #(
        .MAX_BLOCK(MAX_BLOCK)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample     (pcm_sample),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_level      (level),
        .i_mean_square(mean_square),
        .o_fail_count (fail_count),
        .o_results_due(results_due)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // The result consumer stalls at random; with rx_idle_pct at zero it never stalls.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: any transaction on either channel restarts the count. It also counts
    // result transactions so that the random part knows when enough blocks have ended.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (out_valid && out_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    // Offer one sample and hold it until the meter takes it. Random idle cycles go in
    // front of the transaction; valid stays high on return so that back-to-back samples
    // never lower and raise it in the same time step.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        pcm_sample <= value;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        items_sent++;
    endtask

    // Stop sending, wait for every outstanding block result, let the post-processing
    // pipeline go quiet, then write the block length. Any partial block stays in the
    // accumulator, which is how a mid-block length change is exercised.
    task automatic load_length(input logic [CFG_W-1:0] len);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Samples from four loudness classes, so that the mean square and the level
    // spread from silence to full scale. The first class toggles every sample bit.
    function automatic logic signed [SAMPLE_W-1:0] rand_pcm();
        logic [SAMPLE_W-1:0] raw;
        raw = SAMPLE_W'($urandom);
        case ($urandom_range(3))
            0: return raw;
            1: return SAMPLE_W'($signed(raw[5:0]));
            2: return raw[0] ? SAMPLE_W'(-32768 + $urandom_range(255))
                             : SAMPLE_W'(32767 - $urandom_range(255));
            default: return SAMPLE_W'($signed(raw[11:0]));
        endcase
    endfunction

    initial begin
        logic signed [SAMPLE_W-1:0] corners [9];
        int phase;
        int random_start;
        corners = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
                    16'sh5555, -16'sh5556, 16'sh00FF, -16'sh0100};

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // The first block runs at the reset length of 1000 samples and opens with
        // the corner values of the sample field.
        foreach (corners[i]) begin
            push_sample(corners[i]);
        end
        repeat (1000 - 9) push_sample(rand_pcm());

        // Shorten the length below the count already taken: the very next sample
        // ends the block, and the mean divides by the new length.
        repeat (100) push_sample(rand_pcm());
        load_length(CFG_W'(MIN_BLOCK));
        push_sample(rand_pcm());

        // A zero register acts as the shortest block. Full-scale negative samples
        // give the largest mean square, then silence, full-scale positive, and a
        // block whose mean is exactly one.
        load_length('0);
        repeat (MIN_BLOCK) push_sample(-16'sd32768);
        repeat (MIN_BLOCK) push_sample(16'sd0);
        repeat (MIN_BLOCK) push_sample(16'sd32767);
        for (int i = 0; i < MIN_BLOCK; i++) begin
            push_sample(i[0] ? 16'sd1 : -16'sd1);
        end

        // Random part: short blocks, a new length every phase, sometimes below the
        // minimum. The idle pattern swaps after a third and stops after two thirds.
        phase        = 0;
        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS || results_seen < RANDOM_RESULTS) begin
            if (phase == 6) begin
                tx_idle_pct = 67;
                rx_idle_pct = 30;
            end else if (phase == 12) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase % 4 == 0) begin
                load_length(CFG_W'($urandom_range(MIN_BLOCK - 1)));
            end else begin
                load_length(CFG_W'($urandom_range(MIN_BLOCK, 100)));
            end
            repeat (PHASE_ITEMS) push_sample(rand_pcm());
            phase++;
        end

        // The longest blocks: an all-ones register saturates to MAX_BLOCK, then the
        // exact maximum. A partial block is left in the accumulator at the end.
        load_length('1);
        repeat (MAX_BLOCK) push_sample(rand_pcm());
        load_length(CFG_W'(MAX_BLOCK));
        repeat (MAX_BLOCK + 37) push_sample(rand_pcm());

        // Drain: wait for the last result, then give the pipeline time to show any
        // stray transaction.
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && results_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/abl_pkg.sv
rtl/abl_ctrl.sv
rtl/abl_dpath.sv
rtl/audio_block_level_meter_core.sv
rtl/abl_checker.sv
verif/level_meter_checker.sv
verif/tb_top.sv
